// ===== src/edwf_pkg.sv =====
// Shared types and constants for the echo width distance filter.
// No dependencies; imported by every module of the block.
package edwf_pkg;

    localparam int CHANNELS_DEF      = 3;
    localparam int AVERAGE_DEPTH_DEF = 5;
    localparam int TIMER_BITS_DEF    = 16;

    localparam int CH_W        = 2;
    localparam int SAMPLE_W    = 11;
    localparam int SAMPLE_MAX  = 2047;
    localparam int SPIKE_RESET = 50;

    // width / 58 by reciprocal multiply; widths at or above SAT_WIDTH saturate
    localparam int CM_DIVISOR = 58;
    localparam int SAT_WIDTH  = (SAMPLE_MAX + 1) * CM_DIVISOR;
    localparam int CM_IN_W    = $clog2(SAT_WIDTH);
    localparam int CM_SHIFT   = CM_IN_W + $clog2(CM_DIVISOR);
    localparam int CM_RECIP_W = CM_SHIFT - $clog2(CM_DIVISOR) + 1;
    localparam int CM_RECIP   = (2**CM_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR;
    localparam int CM_PROD_W  = CM_IN_W + CM_RECIP_W;

    typedef struct packed {
        logic                vld;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
    } hist_req_t;

    typedef struct packed {
        logic                vld;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] distance;
        logic                replaced;
    } avg_res_t;

endpackage

// ===== src/edwf_avg.sv =====
// Per-channel sample history: spike filter, running sum and floored average.
// History rows live in a registered-read memory with read-modify-write bypass.
// Depends on edwf_pkg.
module edwf_avg #(
    parameter int CHANNELS      = edwf_pkg::CHANNELS_DEF,
    parameter int AVERAGE_DEPTH = edwf_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [edwf_pkg::SAMPLE_W-1:0] spike_limit,
    input  edwf_pkg::hist_req_t           req,
    output logic                          ready,
    input  logic                          out_stall,
    output edwf_pkg::avg_res_t            res
);
    import edwf_pkg::*;

    localparam int AW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W     = $clog2(AVERAGE_DEPTH * SAMPLE_MAX + 1);
    localparam int HIST_W    = AVERAGE_DEPTH * SAMPLE_W;
    localparam int ROW_W     = HIST_W + SUM_W;
    localparam int AVG_SHIFT = SUM_W + $clog2(AVERAGE_DEPTH);
    localparam int PROD_W    = SUM_W + AVG_SHIFT + 1;
    localparam logic [AVG_SHIFT:0] AVG_RECIP =
        (AVG_SHIFT + 1)'((2**AVG_SHIFT + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH);

    logic [ROW_W-1:0]    hist_mem [CHANNELS];
    logic [CHANNELS-1:0] hist_ok_reg;
    logic [ROW_W-1:0]    rd_row_reg;
    logic                rd_ok_reg;

    logic                s2_vld_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic [SAMPLE_W-1:0] s2_sample_reg;

    logic                byp_vld_reg;
    logic [AW-1:0]       byp_idx_reg;
    logic [ROW_W-1:0]    byp_row_reg;

    logic                s3_vld_reg;
    logic [CH_W-1:0]     s3_ch_reg;
    logic [SUM_W-1:0]    s3_sum_reg;
    logic                s3_rep_reg;

    logic                s4_vld_reg;
    logic [CH_W-1:0]     s4_ch_reg;
    logic [PROD_W-1:0]   s4_prod_reg;
    logic                s4_rep_reg;

    logic                en2, en3, en4, wr;
    logic [AW-1:0]       req_idx, s2_idx;
    logic [ROW_W-1:0]    cur_row, new_row;
    logic [SAMPLE_W-1:0] hist0, oldest, sample_acc;
    logic [SUM_W-1:0]    cur_sum, sum_new;
    logic                spike;

    assign en4   = !s4_vld_reg || !out_stall;
    assign en3   = !s3_vld_reg || en4;
    assign en2   = !s2_vld_reg || en3;
    assign ready = en2;
    assign wr    = s2_vld_reg && en3;

    assign req_idx = AW'(req.ch);
    assign s2_idx  = AW'(s2_ch_reg);

    always_comb
    begin
        if (byp_vld_reg && (byp_idx_reg == s2_idx))
        begin
            cur_row = byp_row_reg;
        end
        else if (rd_ok_reg)
        begin
            cur_row = rd_row_reg;
        end
        else
        begin
            cur_row = '0;
        end
        hist0      = cur_row[SAMPLE_W-1:0];
        oldest     = cur_row[(AVERAGE_DEPTH-1)*SAMPLE_W +: SAMPLE_W];
        cur_sum    = cur_row[HIST_W +: SUM_W];
        spike      = {1'b0, s2_sample_reg} > ({1'b0, hist0} + {1'b0, spike_limit});
        sample_acc = spike ? hist0 : s2_sample_reg;
        sum_new    = cur_sum - SUM_W'(oldest) + SUM_W'(sample_acc);
        new_row    = '0;
        new_row[SAMPLE_W-1:0] = sample_acc;
        for (int i = 1; i < AVERAGE_DEPTH; i++)
        begin
            new_row[i*SAMPLE_W +: SAMPLE_W] = cur_row[(i-1)*SAMPLE_W +: SAMPLE_W];
        end
        new_row[HIST_W +: SUM_W] = sum_new;
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            hist_mem[s2_idx] <= new_row;
        end
        if (en2 && req.vld)
        begin
            rd_row_reg <= hist_mem[req_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_ok_reg <= '0;
            rd_ok_reg   <= 1'b0;
            s2_vld_reg  <= 1'b0;
            byp_vld_reg <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                hist_ok_reg[s2_idx] <= 1'b1;
            end
            if (en2)
            begin
                s2_vld_reg  <= req.vld;
                byp_vld_reg <= wr;
                if (req.vld)
                begin
                    rd_ok_reg <= hist_ok_reg[req_idx];
                end
            end
            if (en3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_ch_reg     <= req.ch;
            s2_sample_reg <= req.sample;
            byp_idx_reg   <= s2_idx;
            byp_row_reg   <= new_row;
        end
        if (en3)
        begin
            s3_ch_reg  <= s2_ch_reg;
            s3_sum_reg <= sum_new;
            s3_rep_reg <= spike;
        end
        if (en4)
        begin
            s4_ch_reg   <= s3_ch_reg;
            s4_prod_reg <= PROD_W'(s3_sum_reg) * PROD_W'(AVG_RECIP);
            s4_rep_reg  <= s3_rep_reg;
        end
    end

    assign res.vld      = s4_vld_reg;
    assign res.ch       = s4_ch_reg;
    assign res.distance = s4_prod_reg[AVG_SHIFT +: SAMPLE_W];
    assign res.replaced = s4_rep_reg;

endmodule

// ===== src/echo_width_distance_filter.sv =====
// Echo width distance filter top level: edge tracking, width to distance, config.
// Depends on edwf_pkg and edwf_avg.
//
// Usage:
//   Input channel (in_valid / in_stall): one timer capture transaction per echo
//   edge, sensor_channel and capture_time. Edges of a channel alternate rise and
//   fall; a rise gives no result, a fall gives one. Channels at or above CHANNELS
//   are dropped.
//   Output channel (out_valid / out_stall): result_channel, distance_cm (floored
//   mean of the last AVERAGE_DEPTH samples) and spike_replaced.
//   Config channel (cfg_valid / cfg_ready): spike_limit write, always ready.
//   Write it only while no transaction is in flight.
//   Path: a falling-edge transaction is registered in s1, then in the average
//   stages s2, s3 and s4; the s4 registers drive the result.
//   Throughput: one transaction per cycle unless stalled; both per-channel memories do one
//   read-modify-write per cycle with a one-deep bypass on back-to-back hits.
//   Stall: out_stall holds the output register; the stages behind it keep
//   filling bubbles and in_stall rises only when every stage is occupied.
//   Reset: all channels expect a rising edge, histories read as zero and
//   spike_limit is 50; no clearing pass, transactions are taken at once.
module echo_width_distance_filter #(
    parameter int CHANNELS      = edwf_pkg::CHANNELS_DEF,
    parameter int AVERAGE_DEPTH = edwf_pkg::AVERAGE_DEPTH_DEF,
    parameter int TIMER_BITS    = edwf_pkg::TIMER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [edwf_pkg::CH_W-1:0]     sensor_channel,
    input  logic [TIMER_BITS-1:0]         capture_time,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [edwf_pkg::SAMPLE_W-1:0] cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [edwf_pkg::CH_W-1:0]     result_channel,
    output logic [edwf_pkg::SAMPLE_W-1:0] distance_cm,
    output logic                          spike_replaced
);
    import edwf_pkg::*;

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ST_W = TIMER_BITS + 1;

    logic [SAMPLE_W-1:0] spike_limit_reg;

    logic [ST_W-1:0]     st_mem [CHANNELS];
    logic [CHANNELS-1:0] st_ok_reg;
    logic [ST_W-1:0]     st_rd_reg;
    logic                st_rd_ok_reg;

    logic                  s1_vld_reg;
    logic [CH_W-1:0]       s1_ch_reg;
    logic [TIMER_BITS-1:0] s1_time_reg;

    logic                  byp_vld_reg;
    logic [AW-1:0]         byp_idx_reg;
    logic [ST_W-1:0]       byp_row_reg;

    logic                  en1, take, in_range, st_wr, fall, sat;
    logic [AW-1:0]         in_idx, s1_idx;
    logic [ST_W-1:0]       cur_st, new_st;
    logic [TIMER_BITS-1:0] width;
    logic [CM_IN_W-1:0]    cm_in;
    logic [CM_PROD_W-1:0]  cm_prod;
    logic                  avg_ready;
    hist_req_t             req;
    avg_res_t              res;

    assign cfg_ready = 1'b1;

    assign en1      = !s1_vld_reg || avg_ready;
    assign in_stall = !en1;
    assign take     = in_valid && en1;
    assign in_range = int'(sensor_channel) < CHANNELS;
    assign in_idx   = AW'(sensor_channel);
    assign s1_idx   = AW'(s1_ch_reg);
    assign st_wr    = s1_vld_reg && avg_ready;

    always_comb
    begin
        if (byp_vld_reg && (byp_idx_reg == s1_idx))
        begin
            cur_st = byp_row_reg;
        end
        else if (st_rd_ok_reg)
        begin
            cur_st = st_rd_reg;
        end
        else
        begin
            cur_st = '0;
        end
        fall    = cur_st[TIMER_BITS];
        new_st  = fall ? {1'b0, cur_st[TIMER_BITS-1:0]} : {1'b1, s1_time_reg};
        width   = s1_time_reg - cur_st[TIMER_BITS-1:0];
        sat     = 33'(width) >= 33'(SAT_WIDTH);
        cm_in   = CM_IN_W'(33'(width));
        cm_prod = CM_PROD_W'(cm_in) * CM_PROD_W'(CM_RECIP);

        req.vld    = s1_vld_reg && fall;
        req.ch     = s1_ch_reg;
        req.sample = sat ? SAMPLE_W'(SAMPLE_MAX) : cm_prod[CM_SHIFT +: SAMPLE_W];
    end

    always_ff @(posedge clk)
    begin
        if (st_wr)
        begin
            st_mem[s1_idx] <= new_st;
        end
        if (take && in_range)
        begin
            st_rd_reg <= st_mem[in_idx];
        end
        if (en1)
        begin
            s1_ch_reg   <= sensor_channel;
            s1_time_reg <= capture_time;
            byp_idx_reg <= s1_idx;
            byp_row_reg <= new_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_limit_reg <= SAMPLE_W'(SPIKE_RESET);
            st_ok_reg       <= '0;
            st_rd_ok_reg    <= 1'b0;
            s1_vld_reg      <= 1'b0;
            byp_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                spike_limit_reg <= cfg_data;
            end
            if (st_wr)
            begin
                st_ok_reg[s1_idx] <= 1'b1;
            end
            if (en1)
            begin
                s1_vld_reg  <= take && in_range;
                byp_vld_reg <= st_wr;
                if (take && in_range)
                begin
                    st_rd_ok_reg <= st_ok_reg[in_idx];
                end
            end
        end
    end

    edwf_avg #(
        .CHANNELS      (CHANNELS),
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_avg (
        .clk         (clk),
        .rst_n       (rst_n),
        .spike_limit (spike_limit_reg),
        .req         (req),
        .ready       (avg_ready),
        .out_stall   (out_stall),
        .res         (res)
    );

    assign out_valid      = res.vld;
    assign result_channel = res.ch;
    assign distance_cm    = res.distance;
    assign spike_replaced = res.replaced;

endmodule

// ===== src/edwf_check.sv =====
// Port-level checks for echo_width_distance_filter, bound to the top level.
// Depends on edwf_pkg.
module edwf_check #(
    parameter int CHANNELS = edwf_pkg::CHANNELS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [edwf_pkg::CH_W-1:0]     result_channel,
    input logic [edwf_pkg::SAMPLE_W-1:0] distance_cm,
    input logic                          spike_replaced
);
    import edwf_pkg::*;

    // input backs up only when the whole pipe is full behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a stalled result");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (int'(result_channel) < CHANNELS))
        else $error("result on a channel that does not exist");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            ($stable(result_channel) && $stable(distance_cm) && $stable(spike_replaced)))
        else $error("result changed while stalled");

endmodule

bind echo_width_distance_filter edwf_check #(.CHANNELS(CHANNELS)) u_edwf_check (.*);
